// ===== hw/rtl/bpeg_pkg.sv =====
package bpeg_pkg;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_TRIGGER = 2'd2;

   localparam logic CSR_LOOP_ENABLE   = 1'b0;
   localparam logic CSR_SEGMENT_COUNT = 1'b1;

   localparam int TIME_W = 20;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   // quotient magnitude width, two quotient bits per divider step
   localparam int MAG_W     = 38;
   localparam int DIV_STEPS = MAG_W / 2;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic signed [15:0] Q15_MAX = 16'sh7FFF;
   localparam logic signed [15:0] Q15_MIN = 16'sh8000;

   typedef logic [TIME_W-1:0] time_type;
   typedef logic signed [15:0] q15_type;

endpackage

// ===== hw/rtl/breakpoint_envelope_generator.sv =====
// Breakpoint envelope generator, signed Q15 piecewise linear.
// Request words: operation tick (one millisecond), write breakpoint (level
// and duration at entry_index) or trigger (restart at segment 0). Every
// request word produces exactly one response word: level_out, running and
// finished. Configuration: csr index 0 is loop_enable, index 1 is
// segment_count; write only while no request is in flight.
// Path from acceptance to S_OUT, which loads the response word: a write,
// an idle tick or an unused operation goes straight there; a trigger or a
// loop restart passes S_TRIG, the final tick of a non-looping envelope
// S_FIN, a tick in a zero-length segment S_RD1 and S_RD2, and an
// interpolating tick S_RD1, S_RD2, S_MUL, S_DIV and S_ADD. The serial
// divider in S_DIV retires two quotient bits per cycle.
// One request is processed at a time; req_stall is high from acceptance
// until the response is loaded into the output register, so the next
// request is taken while the previous response still waits on rsp_stall.
// A stalled response holds; the block then waits before loading the next.
// Reset clears the time counters, the segment index, the level and the
// running flag and sets segment_count to 1. The breakpoint tables are not
// cleared; read only entries that have been written.
module breakpoint_envelope_generator
   import bpeg_pkg::*;
#(
   parameter int MAX_SEGMENTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_operation,
   input  logic [3:0]        req_entry_index,
   input  logic signed [15:0] req_entry_level,
   input  logic [15:0]       req_entry_duration,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [15:0] rsp_level_out,
   output logic              rsp_running,
   output logic              rsp_finished,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [3:0]        csr_write_data
);

   localparam int LAW = $clog2(MAX_SEGMENTS + 1);
   localparam int DAW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam logic [7:0] MAX_SEG8 = 8'(MAX_SEGMENTS);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_TRIG = 4'd1;
   localparam logic [3:0] S_RD1  = 4'd2;
   localparam logic [3:0] S_RD2  = 4'd3;
   localparam logic [3:0] S_MUL  = 4'd4;
   localparam logic [3:0] S_DIV  = 4'd5;
   localparam logic [3:0] S_ADD  = 4'd6;
   localparam logic [3:0] S_FIN  = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   q15_type lvl_mem [0:MAX_SEGMENTS];
   logic [15:0] dur_mem [0:MAX_SEGMENTS-1];

   logic [3:0] state_ff, state_in;
   time_type elapsed_ff, elapsed_in;
   time_type seg_end_ff, seg_end_in;
   logic [LAW-1:0] seg_ff, seg_in;
   logic active_ff, active_in;
   q15_type cur_ff, cur_in;
   logic fin_ff, fin_in;
   logic loop_ff, loop_in;
   logic [3:0] cnt_ff, cnt_in;
   logic cross_ff, cross_in;
   logic [15:0] d_ff, d_in;
   q15_type a_ff, a_in;
   logic signed [38:0] prod_ff, prod_in;
   logic [MAG_W-1:0] num_ff, num_in;
   logic [15:0] rem_ff, rem_in;
   logic neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   q15_type rsp_level_ff, rsp_level_in;
   logic rsp_running_ff, rsp_running_in;
   logic rsp_finished_ff, rsp_finished_in;

   q15_type lvl_rd_ff;
   logic [15:0] dur_rd_ff;
   logic [LAW-1:0] lvl_raddr;
   logic [DAW-1:0] dur_raddr;

   logic accept;
   logic [7:0] cnt8, n8, idx8;
   logic [LAW-1:0] n_w;
   logic [LAW:0] seg_inc;
   logic last;
   time_type et;
   logic seg_cross;
   logic [TIME_W:0] end_sum;
   logic signed [16:0] diff_w;
   logic signed [21:0] into_w;
   logic signed [38:0] prod_w;
   logic [38:0] mag_w;
   logic [16:0] r1, r1s, r2, r2s;
   logic ge1, ge2;
   logic signed [38:0] q_w;
   logic signed [39:0] sum_w;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   assign cnt8 = {4'b0, cnt_ff};
   assign n8 = (cnt8 == 8'd0) ? 8'd1 : ((cnt8 > MAX_SEG8) ? MAX_SEG8 : cnt8);
   assign n_w = n8[LAW-1:0];
   assign idx8 = {4'b0, req_entry_index};
   assign seg_inc = {1'b0, seg_ff} + {{LAW{1'b0}}, 1'b1};
   assign last = (seg_inc >= {1'b0, n_w});
   assign et = (elapsed_ff == TIME_MAX) ? elapsed_ff : elapsed_ff + 20'd1;
   assign seg_cross = (et > seg_end_ff);
   assign end_sum = {1'b0, seg_end_ff} + {5'b0, dur_rd_ff};

   assign diff_w = {lvl_rd_ff[15], lvl_rd_ff} - {a_ff[15], a_ff};
   assign into_w = $signed({2'b0, elapsed_ff}) - $signed({2'b0, seg_end_ff})
                 + $signed({6'b0, d_ff});
   assign prod_w = diff_w * into_w;
   assign mag_w = prod_ff[38] ? 39'(-prod_ff) : prod_ff;

   // two restoring divide steps per cycle
   assign r1 = {rem_ff, num_ff[MAG_W-1]};
   assign ge1 = (r1 >= {1'b0, d_ff});
   assign r1s = ge1 ? r1 - {1'b0, d_ff} : r1;
   assign r2 = {r1s[15:0], num_ff[MAG_W-2]};
   assign ge2 = (r2 >= {1'b0, d_ff});
   assign r2s = ge2 ? r2 - {1'b0, d_ff} : r2;

   assign q_w = neg_ff ? -$signed({1'b0, num_ff}) : $signed({1'b0, num_ff});
   assign sum_w = $signed({{24{a_ff[15]}}, a_ff}) + $signed({q_w[38], q_w});

   always_comb begin
      lvl_raddr = seg_inc[LAW-1:0];
      dur_raddr = DAW'(seg_ff);
      if (state_ff == S_IDLE) begin
         if (req_operation == OP_TRIGGER) begin
            dur_raddr = '0;
         end else if (seg_cross && last) begin
            lvl_raddr = n_w;
            dur_raddr = '0;
         end else if (seg_cross) begin
            lvl_raddr = seg_inc[LAW-1:0];
            dur_raddr = DAW'(seg_inc);
         end else begin
            lvl_raddr = seg_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_operation == OP_WRITE) begin
         if (idx8 <= MAX_SEG8) begin
            lvl_mem[LAW'(req_entry_index)] <= req_entry_level;
         end
         if (idx8 < MAX_SEG8) begin
            dur_mem[DAW'(req_entry_index)] <= req_entry_duration;
         end
      end
      lvl_rd_ff <= lvl_mem[lvl_raddr];
      dur_rd_ff <= dur_mem[dur_raddr];
   end

   always_comb begin
      state_in = state_ff;
      elapsed_in = elapsed_ff;
      seg_end_in = seg_end_ff;
      seg_in = seg_ff;
      active_in = active_ff;
      cur_in = cur_ff;
      fin_in = fin_ff;
      loop_in = loop_ff;
      cnt_in = cnt_ff;
      cross_in = cross_ff;
      d_in = d_ff;
      a_in = a_ff;
      prod_in = prod_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      rsp_running_in = rsp_running_ff;
      rsp_finished_in = rsp_finished_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_enable) begin
         case (csr_index)
            CSR_LOOP_ENABLE: loop_in = csr_write_data[0];
            CSR_SEGMENT_COUNT: cnt_in = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fin_in = 1'b0;
               state_in = S_OUT;
               if (req_operation == OP_TRIGGER) begin
                  elapsed_in = '0;
                  seg_in = '0;
                  active_in = 1'b1;
                  state_in = S_TRIG;
               end else if (req_operation == OP_TICK && active_ff) begin
                  elapsed_in = et;
                  cross_in = seg_cross;
                  if (seg_cross && last) begin
                     if (loop_ff) begin
                        seg_in = '0;
                        elapsed_in = '0;
                        state_in = S_TRIG;
                     end else begin
                        active_in = 1'b0;
                        state_in = S_FIN;
                     end
                  end else begin
                     if (seg_cross) begin
                        seg_in = seg_inc[LAW-1:0];
                     end
                     state_in = S_RD1;
                  end
               end
            end
         end
         S_TRIG: begin
            seg_end_in = {4'b0, dur_rd_ff};
            state_in = S_OUT;
         end
         S_FIN: begin
            cur_in = lvl_rd_ff;
            fin_in = 1'b1;
            state_in = S_OUT;
         end
         S_RD1: begin
            d_in = dur_rd_ff;
            a_in = lvl_rd_ff;
            if (cross_ff) begin
               seg_end_in = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
            end
            state_in = S_RD2;
         end
         S_RD2: begin
            if (d_ff == 16'd0) begin
               cur_in = lvl_rd_ff;
               state_in = S_OUT;
            end else begin
               prod_in = prod_w;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            neg_in = prod_ff[38];
            num_in = mag_w[MAG_W-1:0];
            rem_in = '0;
            step_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            num_in = {num_ff[MAG_W-3:0], ge1, ge2};
            rem_in = r2s[15:0];
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            if (sum_w > 40'sd32767) begin
               cur_in = Q15_MAX;
            end else if (sum_w < -40'sd32768) begin
               cur_in = Q15_MIN;
            end else begin
               cur_in = sum_w[15:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = cur_ff;
               rsp_running_in = active_ff;
               rsp_finished_in = fin_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         elapsed_ff <= '0;
         seg_end_ff <= '0;
         seg_ff <= '0;
         active_ff <= 1'b0;
         cur_ff <= '0;
         fin_ff <= 1'b0;
         loop_ff <= 1'b0;
         cnt_ff <= 4'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         elapsed_ff <= elapsed_in;
         seg_end_ff <= seg_end_in;
         seg_ff <= seg_in;
         active_ff <= active_in;
         cur_ff <= cur_in;
         fin_ff <= fin_in;
         loop_ff <= loop_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cross_ff <= cross_in;
      d_ff <= d_in;
      a_ff <= a_in;
      prod_ff <= prod_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      step_ff <= step_in;
      rsp_level_ff <= rsp_level_in;
      rsp_running_ff <= rsp_running_in;
      rsp_finished_ff <= rsp_finished_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level_out = rsp_level_ff;
   assign rsp_running = rsp_running_ff;
   assign rsp_finished = rsp_finished_ff;

   a_load_from_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && state_in == S_IDLE) |=> rsp_valid)
      else $error("response not loaded");

   a_fin_not_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_finished && rsp_running))
      else $error("finished while running");

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, seg_ff} < {1'b0, MAX_SEG8[LAW-1:0]} + 1'b1 || seg_ff == MAX_SEG8[LAW-1:0])
      else $error("segment index out of range");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> step_ff < STEP_W'(DIV_STEPS))
      else $error("divider step overrun");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> d_ff != 16'd0)
      else $error("divide by zero");

endmodule
